>>> hdl/pts_pkg.sv
// shared types and constants of the priority thread selector
package pts_pkg;

  localparam int unsigned THREAD_SLOTS_DEF = 16;
  localparam int unsigned IDLE_SLOT        = 0;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned PRIO_W   = 32;
  localparam int unsigned TIME_W   = 63;
  localparam int unsigned SIG_W    = 8;

  localparam logic [TIME_W-1:0] NO_WAKE_TIME = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_SELECT = 2'd1,
    FUNC_WAITER = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic [SIG_W-1:0]         sig;
    logic [TIME_W-1:0]        act;
    logic [TIME_W-1:0]        wake;
    logic signed [PRIO_W-1:0] prio;
  } slot_t;

endpackage

>>> hdl/pts_ram.sv
// generic single write port ram with registered read
module pts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/priority_thread_selector.sv
// top level of the priority thread selector: slot table and scan sequencer
//
// A write word is stored and its result enters the output register at once.
// A select or waiter query scans the slot table in index order through its single
// read port, one slot per cycle, with one shared compare unit judging each slot
// against the running candidate; after the last slot it enters a finish state that
// loads the result into the output register when it is free. Slots carry a
// written bit and a live bit in flip-flops cleared by reset, so an unwritten slot
// reads as zero and no clearing pass follows reset. A new word is taken only while
// the sequencer is idle and the output register is free or being emptied.
module priority_thread_selector #(
  parameter int unsigned THREAD_SLOTS = pts_pkg::THREAD_SLOTS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pts_pkg::FUNC_W-1:0]        func_i,
  input  logic [pts_pkg::SLOT_W-1:0]        slot_i,
  input  logic                              present_i,
  input  logic signed [pts_pkg::PRIO_W-1:0] prio_i,
  input  logic [pts_pkg::TIME_W-1:0]        wake_time_i,
  input  logic [pts_pkg::TIME_W-1:0]        activation_time_i,
  input  logic [pts_pkg::SIG_W-1:0]         signaler_i,
  input  logic [pts_pkg::TIME_W-1:0]        now_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pts_pkg::SLOT_W-1:0]        chosen_o,
  output logic                              found_o,
  output logic [pts_pkg::TIME_W-1:0]        next_wake_o
);

  localparam int unsigned IDXW = $clog2(THREAD_SLOTS);
  localparam logic [IDXW-1:0] LAST_IDX = IDXW'(THREAD_SLOTS - 1);
  localparam logic [IDXW-1:0] IDLE_IDX = IDXW'(pts_pkg::IDLE_SLOT);

  pts_pkg::state_e state_q, state_d;
  pts_pkg::func_e  func_q;
  pts_pkg::func_e  in_func;

  logic [THREAD_SLOTS-1:0] live_q;
  logic [THREAD_SLOTS-1:0] written_q;
  logic                    rd_live_q;
  logic                    rd_written_q;

  logic [IDXW-1:0] proc_q;
  logic [IDXW-1:0] cand_q;
  logic signed [pts_pkg::PRIO_W-1:0] cand_prio_q;
  logic [pts_pkg::TIME_W-1:0] cand_act_q;
  logic [pts_pkg::TIME_W-1:0] wmin_q;
  logic [pts_pkg::TIME_W-1:0] now_q;
  logic [pts_pkg::SIG_W-1:0]  sig_q;

  logic                       out_valid_q;
  logic [pts_pkg::SLOT_W-1:0] chosen_q;
  logic                       found_q;
  logic [pts_pkg::TIME_W-1:0] next_wake_q;

  logic            in_accept;
  logic            out_free;
  logic            in_range;
  logic [IDXW-1:0] waddr;
  logic            ram_we;
  logic [IDXW-1:0] rd_addr;
  logic            start_scan;
  logic            do_scan;
  logic            load_out;
  logic            load_zero;

  pts_pkg::slot_t wdata;
  pts_pkg::slot_t rdata;
  pts_pkg::slot_t slot_d;

  logic                              first;
  logic signed [pts_pkg::PRIO_W-1:0] c_prio;
  logic [pts_pkg::TIME_W-1:0]        c_act;
  logic                              beats;
  logic                              runnable;
  logic                              take;
  logic                              wake_upd;

  assign in_func   = pts_pkg::func_e'(func_i);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != pts_pkg::ST_IDLE) || !out_free;
  assign in_accept = in_valid_i && !in_stall_o;
  assign in_range  = 32'(slot_i) < THREAD_SLOTS;
  assign waddr     = IDXW'(slot_i);

  assign wdata.prio = present_i ? prio_i : '0;
  assign wdata.wake = present_i ? wake_time_i : '0;
  assign wdata.act  = present_i ? activation_time_i : '0;
  assign wdata.sig  = present_i ? signaler_i : '0;

  pts_ram #(
    .WIDTH($bits(pts_pkg::slot_t)),
    .DEPTH(THREAD_SLOTS)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  // unwritten slots read as zero
  assign slot_d = rd_written_q ? rdata : '0;

  // shared compare unit
  assign first    = (proc_q == IDLE_IDX);
  assign c_prio   = first ? slot_d.prio : cand_prio_q;
  assign c_act    = first ? slot_d.act : cand_act_q;
  assign beats    = (slot_d.prio > c_prio) ||
                    ((slot_d.prio == c_prio) && (slot_d.act < c_act));
  assign runnable = slot_d.wake < now_q;

  always_comb begin
    take     = 1'b0;
    wake_upd = 1'b0;
    case (func_q)
      pts_pkg::FUNC_SELECT: begin
        take     = rd_live_q && runnable && beats;
        wake_upd = rd_live_q && !runnable && (slot_d.prio >= c_prio) &&
                   (slot_d.wake < wmin_q);
      end
      pts_pkg::FUNC_WAITER: begin
        take = rd_live_q && (slot_d.sig == sig_q) && beats;
      end
      default: begin
        take     = 1'b0;
        wake_upd = 1'b0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_accept && ((in_func == pts_pkg::FUNC_SELECT) ||
                          (in_func == pts_pkg::FUNC_WAITER))) begin
          state_d = pts_pkg::ST_SCAN;
        end
      end
      pts_pkg::ST_SCAN: begin
        if (proc_q == LAST_IDX) begin
          state_d = pts_pkg::ST_FINISH;
        end
      end
      pts_pkg::ST_FINISH: begin
        if (out_free) begin
          state_d = pts_pkg::ST_IDLE;
        end
      end
      default: state_d = pts_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ram_we     = 1'b0;
    rd_addr    = IDLE_IDX;
    start_scan = 1'b0;
    do_scan    = 1'b0;
    load_out   = 1'b0;
    load_zero  = 1'b0;
    unique case (state_q)
      pts_pkg::ST_IDLE: begin
        if (in_accept) begin
          if ((in_func == pts_pkg::FUNC_SELECT) || (in_func == pts_pkg::FUNC_WAITER)) begin
            start_scan = 1'b1;
          end else begin
            ram_we    = (in_func == pts_pkg::FUNC_WRITE) && in_range;
            load_out  = 1'b1;
            load_zero = 1'b1;
          end
        end
      end
      pts_pkg::ST_SCAN: begin
        do_scan = 1'b1;
        rd_addr = proc_q + 1'b1;
      end
      pts_pkg::ST_FINISH: begin
        load_out = out_free;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pts_pkg::ST_IDLE;
      live_q       <= '0;
      written_q    <= '0;
      rd_live_q    <= 1'b0;
      rd_written_q <= 1'b0;
      proc_q       <= '0;
      func_q       <= pts_pkg::FUNC_WRITE;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_live_q    <= live_q[rd_addr];
      rd_written_q <= written_q[rd_addr];
      if (ram_we) begin
        live_q[waddr]    <= present_i;
        written_q[waddr] <= 1'b1;
      end
      if (start_scan) begin
        proc_q <= '0;
        func_q <= in_func;
      end else if (do_scan && (proc_q != LAST_IDX)) begin
        proc_q <= proc_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // scan datapath and result register
  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      now_q  <= now_i;
      sig_q  <= signaler_i;
      wmin_q <= pts_pkg::NO_WAKE_TIME;
    end
    if (do_scan) begin
      if (take) begin
        cand_q      <= proc_q;
        cand_prio_q <= slot_d.prio;
        cand_act_q  <= slot_d.act;
      end else if (first) begin
        cand_q      <= IDLE_IDX;
        cand_prio_q <= slot_d.prio;
        cand_act_q  <= slot_d.act;
      end
      if (wake_upd) begin
        wmin_q <= slot_d.wake;
      end
    end
    if (load_out) begin
      if (load_zero) begin
        chosen_q    <= '0;
        found_q     <= 1'b0;
        next_wake_q <= '0;
      end else begin
        chosen_q    <= pts_pkg::SLOT_W'(cand_q);
        found_q     <= (cand_q != IDLE_IDX);
        next_wake_q <= (func_q == pts_pkg::FUNC_SELECT) ? wmin_q : '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign chosen_o    = chosen_q;
  assign found_o     = found_q;
  assign next_wake_o = next_wake_q;

  a_accept_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (state_q == pts_pkg::ST_IDLE))
    else $error("word accepted while sequencer busy");

  a_scan_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::ST_SCAN) && (proc_q != LAST_IDX) |=>
      (state_q == pts_pkg::ST_SCAN) && (proc_q == $past(proc_q) + 1'b1))
    else $error("scan counter did not advance");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::ST_SCAN) && (proc_q == LAST_IDX) |=>
      (state_q == pts_pkg::ST_FINISH))
    else $error("scan did not end after last slot");

  a_finish_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pts_pkg::ST_FINISH) && out_free |=>
      out_valid_o && (state_q == pts_pkg::ST_IDLE))
    else $error("scan result not offered");

  a_write_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> written_q[$past(waddr)] && (live_q[$past(waddr)] == $past(present_i)))
    else $error("slot write not recorded");

endmodule
